// ===== rtl/core/ssp_pkg.sv =====
// Shared types and constants for the servo status packet parser.
package ssp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] ERR_MASK = 8'h3F;

  localparam logic [7:0] EXPECTED_ID_RST   = 8'd1;
  localparam logic [7:0] CAPTURE_LIMIT_RST = 8'd2;

  // Configuration register indexes.
  localparam logic CFG_EXPECTED_ID   = 1'b0;
  localparam logic CFG_CAPTURE_LIMIT = 1'b1;

  // Input function codes.
  localparam logic FUNC_BYTE     = 1'b0;
  localparam logic FUNC_DEADLINE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_PARAM  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_TMO    = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_ERR   = 3'd4,
    PH_PARAM = 3'd5,
    PH_CHK   = 3'd6
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] param_index;
    logic [7:0] param_value;
    logic [7:0] param_count;
    logic [7:0] servo_status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] expected_id;
    logic [7:0] capture_limit;
  } ssp_cfg_t;

endpackage

// ===== rtl/core/ssp_stream_if.sv =====
// Valid/ready channel interfaces for the parser's input and result streams.
interface ssp_in_if;
  import ssp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ssp_out_if;
  import ssp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/servo_status_packet_parser.sv =====
// Servo status packet parser: input register, parse step and result register.
//
// Usage: received bytes (func 0) or deadline events (func 1) arrive as
// transfers on in_ch. Each transfer yields zero or one result transfer on
// out_ch: a captured parameter byte, an accepted or rejected packet at the
// checksum byte, or a timeout for a deadline event.
// An item is captured in the input register at its transfer and is parsed
// from there; its result is loaded into the output register when the parse
// step moves, which waits while a held result is not taken on out_ch.
// Throughput: one item per cycle unless out_ch stalls, set by the single parse
// step between the input and output registers; there is no loop or shared unit.
// When out_ch stalls, the output register holds its result and the input
// register holds one more item; in_ch.ready drops only when both are full.
// Reset (rst_n low at a clock edge) empties both registers, returns the
// parser to hunting the first header byte and restores expected_id to 1
// and capture_limit to 2. The user must write the configuration port only while idle; the block does not enforce it.
module servo_status_packet_parser (
  input  logic       clk,
  input  logic       rst_n,
  ssp_in_if.sink     in_ch,
  ssp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);
  import ssp_pkg::*;

  ssp_cfg_t  cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;
  logic      step_en;
  logic      res_valid;
  out_item_t res;

  // The parse stage may move whenever the output register is free or being drained.
  assign advance      = !out_valid_r || out_ch.ready;
  assign step_en      = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_id   <= EXPECTED_ID_RST;
      cfg_r.capture_limit <= CAPTURE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_ID:   cfg_r.expected_id   <= cfg_wdata;
        CFG_CAPTURE_LIMIT: cfg_r.capture_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: refilled on a transfer, emptied when the parse step takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_ch.payload;
    end
  end

  ssp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: loads whenever the parse stage moves, so a stalled result holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_item_r <= res;
    end
  end

endmodule

// ===== rtl/core/ssp_parser.sv =====
// Packet state registers and the byte-wise parse step.
module ssp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  ssp_pkg::in_item_t  item,
  input  ssp_pkg::ssp_cfg_t  cfg,
  output logic               res_valid,
  output ssp_pkg::out_item_t res
);
  import ssp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] err_r, err_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [8:0] cnt_plus2;
  logic [7:0] c;

  assign c = item.rx_byte;
  assign cnt_plus2 = {1'b0, cnt_r} + 9'd3;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res       = '0;
    if (item.func == FUNC_DEADLINE) begin
      res_valid       = 1'b1;
      res.result_kind = KIND_TMO;
      phase_nxt       = PH_HUNT1;
      len_nxt         = '0;
      sum_nxt         = '0;
      err_nxt         = '0;
      cnt_nxt         = '0;
    end else begin
      unique case (phase_r)
        PH_HUNT2: begin
          phase_nxt = (c == HDR_BYTE) ? PH_ID : PH_HUNT1;
        end
        PH_ID: begin
          if (c == cfg.expected_id) begin
            sum_nxt   = c;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_LEN: begin
          len_nxt   = c;
          sum_nxt   = sum_r + c;
          phase_nxt = PH_ERR;
        end
        PH_ERR: begin
          err_nxt   = c;
          sum_nxt   = sum_r + c;
          cnt_nxt   = '0;
          phase_nxt = (len_r > 8'd2) ? PH_PARAM : PH_CHK;
        end
        PH_PARAM: begin
          if (cnt_r < cfg.capture_limit) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_PARAM;
            res.param_index = cnt_r;
            res.param_value = c;
          end
          cnt_nxt = cnt_r + 8'd1;
          sum_nxt = sum_r + c;
          // Incremented count plus two reaches the length: checksum is next.
          if (cnt_plus2 >= {1'b0, len_r}) begin
            phase_nxt = PH_CHK;
          end
        end
        PH_CHK: begin
          res_valid        = 1'b1;
          res.servo_status = err_r;
          if ((~sum_r == c) && ((err_r & ERR_MASK) == 8'd0) && (len_r >= 8'd2)) begin
            res.result_kind = KIND_ACCEPT;
            res.param_count = len_r - 8'd2;
          end else begin
            res.result_kind = KIND_REJECT;
          end
          phase_nxt = PH_HUNT1;
          len_nxt   = '0;
          sum_nxt   = '0;
          err_nxt   = '0;
          cnt_nxt   = '0;
        end
        default: begin
          phase_nxt = (c == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      len_r   <= '0;
      sum_r   <= '0;
      err_r   <= '0;
      cnt_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== sim/ssp_checker.sv =====
// Checker for the servo status packet parser: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module ssp_checker (
  input  logic       clk,
  input  logic       rst_n,
  ssp_in_if          in_ch,
  ssp_out_if         out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);
  import ssp_pkg::*;

  // Shadow copy of the configuration and of the parser state.
  logic [7:0] want_id;
  logic [7:0] cap_limit;
  phase_t     rx_phase;
  logic [7:0] pkt_len;
  logic [7:0] csum;
  logic [7:0] pkt_err;
  logic [7:0] n_params;

  // Status reports predicted but not yet seen on the result channel.
  out_item_t  expected_reports[$];

  task automatic restart_hunt();
    rx_phase = PH_HUNT1;
    pkt_len  = '0;
    csum     = '0;
    pkt_err  = '0;
    n_params = '0;
  endtask

  // Advances the shadow parser by one item and tells whether it reports anything.
  task automatic parse_item(input in_item_t item, output bit emits, output out_item_t rpt);
    logic [7:0] b;
    bit         ok;
    b     = item.rx_byte;
    emits = 1'b0;
    rpt   = '0;
    if (item.func == FUNC_DEADLINE) begin
      rpt.result_kind = KIND_TMO;
      emits = 1'b1;
      restart_hunt();
    end else begin
      case (rx_phase)
        PH_HUNT2: begin
          rx_phase = (b == HDR_BYTE) ? PH_ID : PH_HUNT1;
        end
        PH_ID: begin
          if (b == want_id) begin
            csum     = b;
            rx_phase = PH_LEN;
          end else begin
            rx_phase = PH_HUNT1;
          end
        end
        PH_LEN: begin
          pkt_len  = b;
          csum     = csum + b;
          rx_phase = PH_ERR;
        end
        PH_ERR: begin
          pkt_err  = b;
          csum     = csum + b;
          n_params = '0;
          rx_phase = (pkt_len > 8'd2) ? PH_PARAM : PH_CHK;
        end
        PH_PARAM: begin
          if (n_params < cap_limit) begin
            rpt.result_kind = KIND_PARAM;
            rpt.param_index = n_params;
            rpt.param_value = b;
            emits = 1'b1;
          end
          n_params = n_params + 8'd1;
          csum     = csum + b;
          if ({1'b0, n_params} + 9'd2 >= {1'b0, pkt_len}) rx_phase = PH_CHK;
        end
        PH_CHK: begin
          ok = ((csum ^ 8'hFF) == b) && ((pkt_err & ERR_MASK) == 8'd0) && (pkt_len >= 8'd2);
          if (ok) begin
            rpt.result_kind = KIND_ACCEPT;
            rpt.param_count = pkt_len - 8'd2;
          end else begin
            rpt.result_kind = KIND_REJECT;
          end
          rpt.servo_status = pkt_err;
          emits = 1'b1;
          restart_hunt();
        end
        default: begin
          rx_phase = (b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    out_item_t rpt;
    bit        emits;
    if (!rst_n) begin
      want_id   = EXPECTED_ID_RST;
      cap_limit = CAPTURE_LIMIT_RST;
      restart_hunt();
      expected_reports.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_reports.size() == 0) begin
          $error("result_kind: expected no result, got %0d", got.result_kind);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
          check_field("param_index", want.param_index, got.param_index);
          check_field("param_value", want.param_value, got.param_value);
          check_field("param_count", want.param_count, got.param_count);
          check_field("servo_status", want.servo_status, got.servo_status);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXPECTED_ID:   want_id   = cfg_wdata;
          CFG_CAPTURE_LIMIT: cap_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        parse_item(in_ch.payload, emits, rpt);
        if (emits) expected_reports.push_back(rpt);
      end
    end
    pending = expected_reports.size();
  end

endmodule

// ===== sim/servo_status_packet_parser_tb.sv =====
// Testbench top for the servo status packet parser: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module servo_status_packet_parser_tb;
  import ssp_pkg::*;

  // The run is cut off here; the slowest legal run stays far below it.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to let pass after the last expected result, covering items still in the input and output registers.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 255;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         pending;

  ssp_in_if  in_ch();
  ssp_out_if out_ch();

  // Flow control knobs, in percent, changed between traffic phases.
  int send_idle_pct;
  int recv_stall_pct;
  // A request for a long receiver hold-off, picked up once by the receiver process.
  int hold_req;
  int items_sent;
  int cycle_count = 0;
  // The id the traffic generator aims its packets at.
  logic [7:0] cur_id;

  servo_status_packet_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ssp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Receiver side. It stalls at random per the current knob, and when a
  // hold-off is requested it keeps ready low for that many cycles, counting
  // them here, while the sender keeps offering items so the block backs up.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0 && !hold_taken) begin
        hold_left = hold_req;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  // Offers one item and returns once its transfer has happened. Valid stays
  // high across back-to-back items; random idle cycles drop it in between.
  task automatic send_item(input logic func, input logic [7:0] rx_byte);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.payload.func = func;
    in_ch.payload.rx_byte = rx_byte;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_deadline();
    send_item(FUNC_DEADLINE, 8'($urandom_range(0, 255)));
  endtask

  // Builds a status packet with random parameters and sends it. bad_chk
  // corrupts the checksum; a nonzero cut sends only that many bytes and then
  // a deadline, as when the servo stops answering mid-packet.
  task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err, input bit bad_chk, input int cut);
    logic [7:0] pkt[$];
    logic [7:0] sum;
    logic [7:0] p;
    int         n_par;
    int         n_send;
    pkt = {HDR_BYTE, HDR_BYTE, id, len, err};
    sum = id + len + err;
    n_par = (len > 8'd2) ? int'(len) - 2 : 0;
    for (int i = 0; i < n_par; i++) begin
      p = 8'($urandom_range(0, 255));
      pkt.push_back(p);
      sum = sum + p;
    end
    pkt.push_back((sum ^ 8'hFF) ^ (bad_chk ? 8'($urandom_range(1, 255)) : 8'h00));
    n_send = (cut == 0) ? pkt.size() : cut;
    for (int i = 0; i < n_send; i++) send_item(FUNC_BYTE, pkt[i]);
    if (cut != 0) send_deadline();
  endtask

  // Mostly short packets, a few with a too-short length, rarely long ones.
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'($urandom_range(0, 1));
    if (r < 96) return 8'($urandom_range(2, 12));
    return 8'($urandom_range(13, 255));
  endfunction

  task automatic write_cfg(input logic idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_EXPECTED_ID) cur_id = data;
  endtask

  // Lets the block go idle: no valid offered, every expected result drained,
  // then a settling wait for items that produce nothing.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random traffic: mostly well-formed packets with random content, the rest
  // broken packets, line noise and stray deadlines.
  task automatic random_traffic(input int quota, input bit long_first);
    int         start;
    int         r;
    int         n_noise;
    logic [7:0] len;
    logic [7:0] err;
    start = items_sent;
    if (long_first) send_packet(cur_id, 8'd255, 8'h00, 1'b0, 0);
    while (items_sent - start < quota) begin
      r = $urandom_range(0, 99);
      len = pick_len();
      err = {2'($urandom_range(0, 3)), 6'b0};
      if (r < 70) begin
        send_packet(cur_id, len, err, 1'b0, 0);
      end else if (r < 78) begin
        // Any of the low six error bits set must reject the packet.
        err = 8'($urandom_range(0, 255)) | (8'd1 << $urandom_range(0, 5));
        send_packet(cur_id, len, err, 1'b0, 0);
      end else if (r < 84) begin
        send_packet(cur_id, len, err, 1'b1, 0);
      end else if (r < 88) begin
        send_packet(cur_id ^ 8'($urandom_range(1, 255)), len, err, 1'b0, 0);
      end else if (r < 93) begin
        send_packet(cur_id, len, err, 1'b0,
                    $urandom_range(1, 5 + ((len > 8'd2) ? int'(len) - 2 : 0)));
      end else if (r < 97) begin
        // Noise ends on a non-header byte so the next packet is framed cleanly.
        n_noise = $urandom_range(1, 6);
        repeat (n_noise) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
        send_item(FUNC_BYTE, 8'($urandom_range(0, 254)));
      end else begin
        send_deadline();
      end
    end
    // A deadline leaves the parser hunting before the next setting.
    send_deadline();
  endtask

  initial begin
    logic [7:0] phase_id[6];
    logic [7:0] phase_lim[6];
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_EXPECTED_ID;
    cfg_wdata = 8'd0;
    hold_req = 0;
    items_sent = 0;
    cur_id = EXPECTED_ID_RST;
    set_idling(0);

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_cfg(CFG_EXPECTED_ID, 8'd1);
    write_cfg(CFG_CAPTURE_LIMIT, 8'd2);

    // Directed part. A deadline while hunting still reports a timeout.
    send_deadline();
    // Header match with a wrong id falls back to hunting silently.
    send_item(FUNC_BYTE, HDR_BYTE);
    send_item(FUNC_BYTE, HDR_BYTE);
    send_item(FUNC_BYTE, 8'h07);
    // Three-byte length: one parameter of value zero, accepted with the top
    // error bit set since only the low six bits count.
    send_item(FUNC_BYTE, HDR_BYTE);
    send_item(FUNC_BYTE, HDR_BYTE);
    send_item(FUNC_BYTE, 8'h01);
    send_item(FUNC_BYTE, 8'h03);
    send_item(FUNC_BYTE, 8'h80);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'h7B);
    // Length two with an error bit set: straight to the checksum, rejected.
    send_packet(8'h01, 8'd2, 8'h20, 1'b0, 0);
    // Length zero: rejected whatever the checksum byte, here all ones.
    send_item(FUNC_BYTE, HDR_BYTE);
    send_item(FUNC_BYTE, HDR_BYTE);
    send_item(FUNC_BYTE, 8'h01);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'hFF);
    // Deadline in the middle of a packet aborts it.
    send_packet(8'h01, 8'd5, 8'h00, 1'b0, 4);

    // Traffic phases, each with its own setting, extremes among them.
    phase_id  = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    phase_lim = '{8'd2, 8'd0, 8'd253, 8'd255, 8'($urandom_range(0, 12)), 8'd254};
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_cfg(CFG_EXPECTED_ID, phase_id[ph]);
      write_cfg(CFG_CAPTURE_LIMIT, phase_lim[ph]);
      set_idling((ph == 5) ? 3 : ph);
      // In the first phase the receiver holds off for a long stretch while
      // the sender never idles, so both registers fill and input stalls.
      if (ph == 0) hold_req = 400;
      random_traffic(PHASE_ITEMS, (ph == 2) || (ph == 3));
    end

    drain();
    set_idling(0);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
